// ----- hdl/ppa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ppa_pkg;

  // Area geometry
  localparam int PAGE_COUNT = 256;
  localparam int PAGE_SHIFT = 12;

  // Field widths
  localparam int ADDR_W   = 32;
  localparam int LIM_W    = 9;
  localparam int STAT_W   = 3;
  localparam int IDX_W    = $clog2(PAGE_COUNT + 1);
  localparam int RAM_AW   = $clog2(PAGE_COUNT);
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = CFG_IDX_W'(1);

  // Request kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_EXHAUSTED  = 3'd1,
    STAT_MISALIGNED = 3'd2,
    STAT_OUTSIDE    = 3'd3,
    STAT_NONE_USED  = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ----- hdl/page_pool_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Page allocator for one area of fixed-size pages starting at base_address
// (register 0, low page-offset bits ignored) and holding min(page_limit,
// PAGE_COUNT) pages (register 1). An allocate word pops the most recently
// freed page from a LIFO free list held in a link memory, else takes the
// next never-used page from a bump pointer, else reports exhausted. A free
// word is checked for alignment, then area membership, then that some page
// is in use, and is pushed on the free list. The accept cycle of an input
// word reads the link memory at the list head; the ST_EXEC state then
// decides, writes the link memory back and loads the output register, and
// stays there while a held output waits. The next input word is taken while
// a result still waits in the output register. The link memory needs no
// clearing pass after reset. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
module page_pool_allocator
  import ppa_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ADDR_W-1:0]     cfg_data_i,
  // Request stream
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // [31:0] free_address
  input  wire logic                  s_axis_tuser_i,  // [0] func
  // Result stream
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o   // [31:0] page_address,
                                                      // [34:32] status,
                                                      // [35] pool_full,
                                                      // [36] area_empty,
                                                      // [39:37] zero
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e                state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]     base_q;
  logic [LIM_W-1:0]      limit_q;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [IDX_W-1:0]      bump_q, bump_d;
  logic [IDX_W-1:0]      used_q, used_d;
  logic                  func_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [ADDR_W-1:0]     page_addr_q, page_addr_d;
  status_e               status_q, status_d;
  logic                  full_q, full_d;
  logic                  empty_q, empty_d;

  logic                  in_fire;
  logic                  commit;
  logic [IDX_W-1:0]      limit_eff;
  logic [ADDR_W-1:0]     base_eff;
  logic [ADDR_W-1:0]     addr_diff;
  logic [ADDR_W-1:0]     addr_page;
  logic [IDX_W-1:0]      grant_idx;
  logic [IDX_W-1:0]      link_rdata;
  logic                  link_we;
  logic [RAM_AW-1:0]     link_waddr;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready_i);

  // Free-list links, read at the head every cycle
  ppa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (PAGE_COUNT)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (head_q),
    .raddr_i (head_q[RAM_AW-1:0]),
    .rdata_o (link_rdata)
  );

  // Effective area bounds
  always_comb begin
    if (32'(limit_q) >= 32'(PAGE_COUNT)) begin
      limit_eff = IDX_W'(PAGE_COUNT);
    end else begin
      limit_eff = IDX_W'(limit_q);
    end
    base_eff  = base_q & ~ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    addr_diff = addr_q - base_eff;
    addr_page = addr_diff >> PAGE_SHIFT;
  end

  // Decide the request and form the result
  always_comb begin
    head_d      = head_q;
    bump_d      = bump_q;
    used_d      = used_q;
    page_addr_d = '0;
    status_d    = STAT_OK;
    link_we     = 1'b0;
    link_waddr  = addr_page[RAM_AW-1:0];
    grant_idx   = head_q;

    if (func_q == FUNC_ALLOC) begin
      if (32'(head_q) < 32'(PAGE_COUNT)) begin
        grant_idx = head_q;
        head_d    = link_rdata;
        if (32'(used_q) < 32'(PAGE_COUNT)) used_d = used_q + IDX_W'(1);
      end else if (bump_q < limit_eff) begin
        grant_idx = bump_q;
        bump_d    = bump_q + IDX_W'(1);
        if (32'(used_q) < 32'(PAGE_COUNT)) used_d = used_q + IDX_W'(1);
      end else begin
        status_d = STAT_EXHAUSTED;
      end
      if (status_d == STAT_OK) begin
        page_addr_d = base_eff + (ADDR_W'(grant_idx) << PAGE_SHIFT);
      end
    end else begin
      if (addr_q[PAGE_SHIFT-1:0] != '0) begin
        status_d = STAT_MISALIGNED;
      end else if ((addr_q < base_eff) || (addr_page >= ADDR_W'(limit_eff))) begin
        status_d = STAT_OUTSIDE;
      end else if (used_q == '0) begin
        status_d = STAT_NONE_USED;
      end else begin
        link_we = commit;
        head_d  = IDX_W'(addr_page);
        used_d  = used_q - IDX_W'(1);
      end
    end

    full_d  = (used_d == limit_eff);
    empty_d = (used_d == '0);
  end

  // Sequence the two steps and hold the output register
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      head_q      <= IDX_W'(PAGE_COUNT);
      bump_q      <= '0;
      used_q      <= '0;
      base_q      <= '0;
      limit_q     <= LIM_W'(256);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        head_q <= head_d;
        bump_q <= bump_d;
        used_q <= used_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_BASE)  base_q  <= cfg_data_i;
        if (cfg_index_i == CFG_LIMIT) limit_q <= cfg_data_i[LIM_W-1:0];
      end
    end
  end

  // Capture the request word and the result word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= s_axis_tuser_i;
      addr_q <= s_axis_tdata_i[ADDR_W-1:0];
    end
    if (commit) begin
      page_addr_q <= page_addr_d;
      status_q    <= status_d;
      full_q      <= full_d;
      empty_q     <= empty_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, empty_q, full_q, status_q, page_addr_q};

  // Checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= 32'(PAGE_COUNT))
    else $error("used count above page count");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q) <= 32'(PAGE_COUNT) && 32'(bump_q) <= 32'(PAGE_COUNT))
    else $error("free head or bump pointer out of range");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o)
    else $error("request accepted while one is at work");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit |=> $stable(used_q) && $stable(head_q) && $stable(bump_q))
    else $error("allocator state changed without a committed request");

endmodule

`default_nettype wire

// ----- hdl/ppa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ppa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
